// ----- src/bcc_pkg.sv -----
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared codes and step counts for the binomial coefficient core.
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int unsigned FieldWidth = 6;
  localparam int unsigned CalcWidth  = 64;
  localparam int unsigned MulSteps   = FieldWidth;
  localparam int unsigned DivSteps   = CalcWidth;

  localparam int unsigned InDataWidth  = 16;
  localparam int unsigned OutDataWidth = 72;

  typedef logic [1:0] status_t;

  localparam status_t StatusOk   = 2'd0;
  localparam status_t StatusNBig = 2'd1;
  localparam status_t StatusKBig = 2'd2;

endpackage

// ----- src/binomial_coefficient_core.sv -----
// ----------------------------------------------------------------------------
// binomial_coefficient_core
// Computes C(n,k) multiplicatively with a bit-serial multiplier and a
// bit-serial restoring divider; reports status for out-of-range operands.
// ----------------------------------------------------------------------------
// channel  direction  tdata fields (low bit up)                tuser  tlast
// s_axis   in         top_count[5:0], choose_count[11:6]       -      -
// m_axis   out        coefficient[63:0], status[65:64], zero   -      -
//
// Each factor of the product runs a shift-add multiply, then a restoring
// divide by i; error items, k = 0 and k = n+1 go straight to finish.
// One item is in work at a time; a finished result waits in the output
// register while the next item is accepted and worked on.
// Reset sets i and k to one and clears every other register; no clearing pass.
// ----------------------------------------------------------------------------
module binomial_coefficient_core
  import bcc_pkg::*;
#(
  parameter int unsigned RESULT_WIDTH = 64,
  parameter int unsigned N_LIMIT      = 63
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // top_count[5:0], choose_count[11:6], zero fill
  input  logic [InDataWidth-1:0]  s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // coefficient[63:0], status[65:64], zero fill
  output logic [OutDataWidth-1:0] m_axis_tdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FINISH
  } state_e;

  state_e                  state_q, state_d;
  logic [FieldWidth-1:0]   n_q, n_d;
  logic [FieldWidth-1:0]   k_q, k_d;
  logic [FieldWidth-1:0]   i_q, i_d;
  logic [FieldWidth-1:0]   mul_q, mul_d;
  logic [FieldWidth-1:0]   cnt_q, cnt_d;
  logic [FieldWidth-1:0]   rem_q, rem_d;
  logic [CalcWidth-1:0]    acc_q, acc_d;
  logic [CalcWidth-1:0]    prod_q, prod_d;
  status_t                 stat_q, stat_d;
  logic                    out_valid_q, out_valid_d;
  logic [RESULT_WIDTH-1:0] out_res_q, out_res_d;
  status_t                 out_stat_q, out_stat_d;

  logic [FieldWidth-1:0]   n_in, k_in;
  logic [FieldWidth:0]     n_plus1;
  logic [FieldWidth:0]     trial;
  logic                    fits;
  logic                    out_free;

  assign n_in     = s_axis_tdata[FieldWidth-1:0];
  assign k_in     = s_axis_tdata[2*FieldWidth-1:FieldWidth];
  assign n_plus1  = {1'b0, n_in} + (FieldWidth+1)'(1);
  assign trial    = {rem_q, prod_q[CalcWidth-1]};
  assign fits     = trial >= {1'b0, i_q};
  assign out_free = !out_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataWidth-CalcWidth-2)'(0), out_stat_q,
                          CalcWidth'(out_res_q)};

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    k_d         = k_q;
    i_d         = i_q;
    mul_d       = mul_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    out_stat_d  = out_stat_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          n_d    = n_in;
          k_d    = k_in;
          i_d    = FieldWidth'(1);
          mul_d  = n_in;
          cnt_d  = '0;
          prod_d = '0;
          acc_d  = CalcWidth'(1);
          stat_d = StatusOk;
          if (n_in >= FieldWidth'(N_LIMIT)) begin
            stat_d  = StatusNBig;
            acc_d   = '0;
            state_d = ST_FINISH;
          end else if ({1'b0, k_in} > n_plus1) begin
            stat_d  = StatusKBig;
            acc_d   = '0;
            state_d = ST_FINISH;
          end else if ({1'b0, k_in} == n_plus1) begin
            acc_d   = '0;
            state_d = ST_FINISH;
          end else if (k_in == '0) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        prod_d = {prod_q[CalcWidth-2:0], 1'b0} +
                 (mul_q[FieldWidth-1] ? acc_q : '0);
        mul_d  = {mul_q[FieldWidth-2:0], 1'b0};
        if (cnt_q == FieldWidth'(MulSteps-1)) begin
          cnt_d   = '0;
          rem_d   = '0;
          state_d = ST_DIV;
        end else begin
          cnt_d = cnt_q + FieldWidth'(1);
        end
      end
      ST_DIV: begin
        rem_d  = fits ? FieldWidth'(trial - {1'b0, i_q}) : trial[FieldWidth-1:0];
        prod_d = {prod_q[CalcWidth-2:0], fits};
        if (cnt_q == FieldWidth'(DivSteps-1)) begin
          cnt_d = '0;
          acc_d = {prod_q[CalcWidth-2:0], fits};
          if (i_q == k_q) begin
            state_d = ST_FINISH;
          end else begin
            i_d     = i_q + FieldWidth'(1);
            mul_d   = n_q - i_q;
            prod_d  = '0;
            state_d = ST_MUL;
          end
        end else begin
          cnt_d = cnt_q + FieldWidth'(1);
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_res_d   = acc_q[RESULT_WIDTH-1:0];
          out_stat_d  = stat_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      i_q         <= FieldWidth'(1);
      k_q         <= FieldWidth'(1);
      rem_q       <= '0;
      n_q         <= '0;
      mul_q       <= '0;
      cnt_q       <= '0;
      acc_q       <= '0;
      prod_q      <= '0;
      stat_q      <= StatusOk;
      out_res_q   <= '0;
      out_stat_q  <= StatusOk;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      i_q         <= i_d;
      k_q         <= k_d;
      rem_q       <= rem_d;
      n_q         <= n_d;
      mul_q       <= mul_d;
      cnt_q       <= cnt_d;
      acc_q       <= acc_d;
      prod_q      <= prod_d;
      stat_q      <= stat_d;
      out_res_q   <= out_res_d;
      out_stat_q  <= out_stat_d;
    end
  end

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stat_q != StatusOk) |-> (out_res_q == '0))
    else $error("error result carries a nonzero coefficient");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> ({1'b0, rem_q} < {1'b0, i_q}))
    else $error("divider remainder not below divisor");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL || state_q == ST_DIV) |-> (i_q != '0 && i_q <= k_q))
    else $error("iteration index out of range");

  a_finish_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && out_free) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("finished result not loaded into output register");

endmodule
